FILE: sv/spatial_cell_hash_table_macros.svh
// assertion macros for the spatial cell hash table
`ifndef SPATIAL_CELL_HASH_TABLE_MACROS_SVH
`define SPATIAL_CELL_HASH_TABLE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SCHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication outside reset
`define SCHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/scht_pkg.sv
// shared types and constants, including the hash multipliers, for the spatial cell hash table
`timescale 1ns / 1ps
package scht_pkg;

   localparam int NUM_BUCKETS_DEF = 1024;
   localparam int CHAIN_WAYS_DEF  = 4;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int COORD_BITS  = 16;
   localparam int KEY_BITS    = 3 * COORD_BITS;
   localparam int SUM_BITS    = 27;
   localparam int MUL_I       = 541;
   localparam int MUL_J       = 79;
   localparam int MUL_K       = 31;

   // request modes, the spare code acts as a lookup
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   // response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_RECIP,
      ST_REDUCE,
      ST_READ,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear;
      logic load;
      logic hash;
      logic recip;
      logic reduce;
      logic read;
      logic scan;
      logic write;
      logic rsp_valid;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rsp_taken;
      logic clear_done;
   } stat_type;

endpackage

FILE: sv/scht_ram.sv
// generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module scht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/scht_ctrl.sv
// controller state machine sequencing the clearing pass, hash, read, scan, write and response
`timescale 1ns / 1ps
module scht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  scht_pkg::stat_type  stat,
   output scht_pkg::cmd_type   cmd
);

   scht_pkg::state_type state_ff, state_in;

   // state register, reset starts the row clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scht_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         scht_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = scht_pkg::ST_IDLE;
            end
         end
         scht_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = scht_pkg::ST_HASH;
            end
         end
         scht_pkg::ST_HASH: begin
            cmd.hash = 1'b1;
            state_in = scht_pkg::ST_RECIP;
         end
         scht_pkg::ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = scht_pkg::ST_REDUCE;
         end
         scht_pkg::ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = scht_pkg::ST_READ;
         end
         scht_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = scht_pkg::ST_SCAN;
         end
         scht_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = scht_pkg::ST_WRITE;
         end
         scht_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = scht_pkg::ST_RESP;
         end
         scht_pkg::ST_RESP: begin
            cmd.rsp_valid = 1'b1;
            if (stat.rsp_taken) begin
               state_in = scht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scht_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/scht_dp.sv
// datapath: bucket hash, chain memory, way compare and chain update
`timescale 1ns / 1ps
module scht_dp #(
   parameter int NUM_BUCKETS = scht_pkg::NUM_BUCKETS_DEF,
   parameter int CHAIN_WAYS  = scht_pkg::CHAIN_WAYS_DEF,
   parameter int HANDLE_BITS = scht_pkg::HANDLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  scht_pkg::cmd_type  cmd,
   output scht_pkg::stat_type stat,
   input  logic [71:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata
);

   localparam int BKT_BITS  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int FILL_BITS = $clog2(CHAIN_WAYS + 1);
   localparam int WAY_BITS  = (CHAIN_WAYS > 1) ? $clog2(CHAIN_WAYS) : 1;
   localparam int ENT_BITS  = scht_pkg::KEY_BITS + HANDLE_BITS;
   localparam int ROW_BITS  = CHAIN_WAYS * ENT_BITS;
   localparam int WORD_BITS = ROW_BITS + FILL_BITS;
   localparam int SB        = scht_pkg::SUM_BITS;
   localparam int CB        = scht_pkg::COORD_BITS;
   localparam int KB        = scht_pkg::KEY_BITS;
   // reciprocal of the bucket count, exact quotient for every magnitude
   localparam int RB        = SB + 2;
   localparam int SHIFT     = SB + BKT_BITS;
   localparam int PB        = SB + RB;
   localparam int QB        = SB + BKT_BITS + 1;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

   // captured request
   logic [1:0]             mode_ff;
   logic [KB-1:0]          key_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   // hash pipeline and bucket state
   logic signed [SB-1:0]   sum_ff, sum_in;
   logic [SB-1:0]          mag_ff, mag_in;
   logic [SB-1:0]          quo_ff, quo_in;
   logic [PB-1:0]          prod_w;
   logic [QB-1:0]          back_w;
   logic [SB-1:0]          rem_w;
   logic [BKT_BITS-1:0]    bkt_ff, bkt_in;
   logic [BKT_BITS-1:0]    clr_ff;
   logic [CHAIN_WAYS-1:0]  hit_ff;
   logic [WORD_BITS-1:0]   word_q;
   logic [ROW_BITS-1:0]    row_w;
   logic [FILL_BITS-1:0]   fill_w;
   logic [ROW_BITS-1:0]    new_row_in;
   logic [WORD_BITS-1:0]   new_word_ff;
   logic [1:0]             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [15:0]            fh_ff, fh_in;
   logic                   wr_ff, wr_in;
   logic [FILL_BITS-1:0]   fill_new_in;
   logic                   ram_wr_en;
   logic [BKT_BITS-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_tdata[1:0];
         key_ff    <= req_tdata[2 +: KB];
         handle_ff <= HANDLE_BITS'(req_tdata[56 +: 16]);
      end
   end

   // bucket hash: |541i + 79j + 31k| mod NUM_BUCKETS, registered as sum, reciprocal quotient, then remainder
   always_comb begin
      sum_in = SB'(signed'(key_ff[0 +: CB])) * SB'(scht_pkg::MUL_I)
             + SB'(signed'(key_ff[CB +: CB])) * SB'(scht_pkg::MUL_J)
             + SB'(signed'(key_ff[2*CB +: CB])) * SB'(scht_pkg::MUL_K);
      mag_in = sum_ff[SB-1] ? SB'(-sum_ff) : SB'(sum_ff);
      prod_w = PB'(mag_in) * PB'(RECIP);
      quo_in = SB'(prod_w >> SHIFT);
      back_w = QB'(quo_ff) * QB'(NUM_BUCKETS);
      rem_w  = mag_ff - SB'(back_w);
      bkt_in = BKT_BITS'(rem_w);
   end

   always_ff @(posedge clock) begin
      if (cmd.hash) begin
         sum_ff <= sum_in;
      end
      if (cmd.recip) begin
         mag_ff <= mag_in;
         quo_ff <= quo_in;
      end
      if (cmd.reduce) begin
         bkt_ff <= bkt_in;
      end
   end

   // clearing pass address after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // row memory write: zero rows while clearing, else commit on response
   always_comb begin
      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wr_ff & cmd.rsp_valid & rsp_tready;
         ram_wr_addr = bkt_ff;
         ram_wr_data = new_word_ff;
      end
   end

   // chain row memory, fill count plus all ways per bucket
   scht_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_BUCKETS)) u_rows (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(bkt_ff),
      .rd_data(word_q)
   );

   assign row_w  = word_q[ROW_BITS-1:0];
   assign fill_w = word_q[ROW_BITS +: FILL_BITS];

   // per-way key compare against valid entries
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         hit_ff <= '0;
      end
      if (cmd.scan) begin
         for (int w = 0; w < CHAIN_WAYS; w++) begin
            hit_ff[w] <= (row_w[w*ENT_BITS +: KB] == key_ff)
                      && (FILL_BITS'(w) < fill_w);
         end
      end
   end

   // first hit, compaction or append
   logic [WAY_BITS-1:0] first_w;
   logic                any_w;
   always_comb begin
      first_w     = '0;
      any_w       = 1'b0;
      for (int w = CHAIN_WAYS - 1; w >= 0; w--) begin
         if (hit_ff[w]) begin
            first_w = WAY_BITS'(w);
            any_w   = 1'b1;
         end
      end
      new_row_in  = row_w;
      status_in   = scht_pkg::STATUS_OK;
      found_in    = 1'b0;
      fh_in       = '0;
      wr_in       = 1'b0;
      fill_new_in = fill_w;
      if (mode_ff == scht_pkg::MODE_INSERT) begin
         if (fill_w >= FILL_BITS'(CHAIN_WAYS)) begin
            status_in = scht_pkg::STATUS_FULL;
         end else begin
            for (int w = 0; w < CHAIN_WAYS; w++) begin
               if (FILL_BITS'(w) == fill_w) begin
                  new_row_in[w*ENT_BITS +: ENT_BITS] = {handle_ff, key_ff};
               end
            end
            wr_in       = 1'b1;
            fill_new_in = fill_w + 1'b1;
         end
      end else if (!any_w) begin
         status_in = scht_pkg::STATUS_NOTFOUND;
      end else begin
         found_in = 1'b1;
         fh_in    = 16'(row_w[first_w*ENT_BITS + KB +: HANDLE_BITS]);
         if (mode_ff == scht_pkg::MODE_REMOVE) begin
            for (int w = 0; w < CHAIN_WAYS - 1; w++) begin
               if (WAY_BITS'(w) >= first_w) begin
                  new_row_in[w*ENT_BITS +: ENT_BITS] =
                     row_w[(w+1)*ENT_BITS +: ENT_BITS];
               end
            end
            wr_in       = 1'b1;
            fill_new_in = fill_w - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         new_word_ff <= {fill_new_in, new_row_in};
         status_ff   <= status_in;
         found_ff    <= found_in;
         fh_ff       <= fh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
      end else if (cmd.scan) begin
         wr_ff <= 1'b0;
      end else if (cmd.write) begin
         wr_ff <= wr_in;
      end
   end

   // status back to the controller
   always_comb begin
      stat.rsp_taken  = cmd.rsp_valid & rsp_tready;
      stat.clear_done = (clr_ff == BKT_BITS'(NUM_BUCKETS - 1));
   end

   assign rsp_tvalid = cmd.rsp_valid;
   assign rsp_tdata  = {5'd0, fh_ff, found_ff, status_ff};

endmodule

FILE: sv/spatial_cell_hash_table.sv
// Spatial cell hash table top level: controller plus datapath.
// rsp_tvalid rises after a request is accepted and has passed the hash sum,
// reciprocal, bucket remainder, row read, scan and update states; one request
// in flight, so the next is accepted only after rsp_tready takes the response.
// Synchronous active-high reset starts a clearing pass over every bucket
// that zeroes every chain row and fill count; req_tready stays low until done.
`timescale 1ns / 1ps
`include "spatial_cell_hash_table_macros.svh"
module spatial_cell_hash_table #(
   parameter int NUM_BUCKETS = scht_pkg::NUM_BUCKETS_DEF,
   parameter int CHAIN_WAYS  = scht_pkg::CHAIN_WAYS_DEF,
   parameter int HANDLE_BITS = scht_pkg::HANDLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], coord_i[17:2], coord_j[33:18], coord_k[49:34], cell_handle[65:50]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], found[2], found_handle[18:3]
   output logic [23:0] rsp_tdata
);

   scht_pkg::cmd_type  cmd;
   scht_pkg::stat_type stat;
   logic [71:0]        req_fix;

   // repack so the datapath sees the handle in the top bits
   assign req_fix = {req_tdata[65:50], 6'd0, req_tdata[49:0]};

   scht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scht_dp #(
      .NUM_BUCKETS(NUM_BUCKETS),
      .CHAIN_WAYS (CHAIN_WAYS),
      .HANDLE_BITS(HANDLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_fix),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   `SCHT_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready, "accept while responding")
   `SCHT_ASSERT_IMPL(a_found_status, clock, reset, rsp_tvalid && rsp_tdata[2], rsp_tdata[1:0] == scht_pkg::STATUS_OK, "found with bad status")
   `SCHT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "second accept")

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the spatial cell hash table
`timescale 1ns / 1ps
module testbench;

   localparam int NB = scht_pkg::NUM_BUCKETS_DEF;
   localparam int NW = scht_pkg::CHAIN_WAYS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1730;

   typedef struct packed {
      logic [15:0] ci;
      logic [15:0] cj;
      logic [15:0] ck;
   } cell_key_type;

   typedef struct {
      logic [1:0]  status;
      logic        found;
      logic [15:0] handle;
   } table_reply_type;

   // table model and queue of predicted replies
   class hash_table_scoreboard;
      cell_key_type    keys[NB][NW];
      logic [15:0]     handles[NB][NW];
      int              fill[NB];
      table_reply_type pending[$];
      int              errors;
      int              checked;
      int              hits;
      int              fulls;

      function int bucket_index(cell_key_type k);
         longint s;
         s = 541 * longint'($signed(k.ci)) + 79 * longint'($signed(k.cj))
             + 31 * longint'($signed(k.ck));
         if (s < 0) s = -s;
         return int'(s % NB);
      endfunction

      function void note_request(logic [1:0] mode, cell_key_type k, logic [15:0] h);
         table_reply_type r;
         int b;
         int w;
         b = bucket_index(k);
         r.status = scht_pkg::STATUS_OK;
         r.found = 1'b0;
         r.handle = '0;
         if (mode == scht_pkg::MODE_INSERT) begin
            if (fill[b] >= NW) begin
               r.status = scht_pkg::STATUS_FULL;
               fulls++;
            end else begin
               keys[b][fill[b]] = k;
               handles[b][fill[b]] = h;
               fill[b]++;
            end
         end else begin
            w = -1;
            for (int x = 0; x < fill[b]; x++)
               if (w < 0 && keys[b][x] == k) w = x;
            if (w < 0) begin
               r.status = scht_pkg::STATUS_NOTFOUND;
            end else begin
               r.found = 1'b1;
               r.handle = handles[b][w];
               hits++;
               if (mode == scht_pkg::MODE_REMOVE) begin
                  for (int x = w; x + 1 < fill[b]; x++) begin
                     keys[b][x] = keys[b][x + 1];
                     handles[b][x] = handles[b][x + 1];
                  end
                  fill[b]--;
               end
            end
         end
         pending.insert(pending.size(), r);
      endfunction

      task report(string what, int got, int want);
         $display("mismatch on %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_reply(logic [23:0] d);
         table_reply_type e;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected reply", d, 0);
            return;
         end
         e = pending.pop_front();
         if (d[1:0] !== e.status) report("status", d[1:0], e.status);
         if (d[2] !== e.found) report("found", d[2], e.found);
         if (d[18:3] !== e.handle) report("found_handle", d[18:3], e.handle);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   hash_table_scoreboard table_sb;
   int sender_idle_pct;
   int receiver_idle_pct;
   int quiet_cycles;
   cell_key_type recent_keys[$];

   spatial_cell_hash_table DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: random stall, check accepted replies
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) table_sb.check_reply(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // send one request, with a random idle gap before it
   task automatic send_request(logic [1:0] mode, cell_key_type k, logic [15:0] h);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, h, k.ck, k.cj, k.ci, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_sb.note_request(mode, k, h);
      recent_keys.insert(recent_keys.size(), k);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
   endtask

   function automatic cell_key_type random_key();
      cell_key_type k;
      // small coordinates crowd a few buckets so chains fill up
      if ($urandom_range(3) == 0)
         k = {16'($urandom), 16'($urandom), 16'($urandom)};
      else
         k = {16'($signed($urandom_range(6)) - 16'sd3),
              16'($signed($urandom_range(6)) - 16'sd3),
              16'($signed($urandom_range(6)) - 16'sd3)};
      return k;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (table_sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      cell_key_type k;
      logic [1:0] mode;
      int pick;
      table_sb = new();
      sender_idle_pct = 32;
      receiver_idle_pct = 77;
      quiet_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme keys, all modes, full chain, duplicates, miss
      k = {16'h7fff, 16'h8000, 16'h0000};
      send_request(scht_pkg::MODE_LOOKUP, k, 16'hffff);
      send_request(scht_pkg::MODE_REMOVE, k, 16'h0000);
      send_request(scht_pkg::MODE_INSERT, k, 16'hffff);
      send_request(scht_pkg::MODE_INSERT, k, 16'h0001);
      send_request(scht_pkg::MODE_LOOKUP, k, 16'h0000);
      send_request(scht_pkg::MODE_INSERT, {16'h8000, 16'h8000, 16'h8000}, 16'h1234);
      send_request(scht_pkg::MODE_INSERT, {16'h7fff, 16'h7fff, 16'h7fff}, 16'h5678);
      send_request(scht_pkg::MODE_INSERT, {16'hffff, 16'hffff, 16'hffff}, 16'h0);
      for (int n = 0; n < 5; n++)
         send_request(scht_pkg::MODE_INSERT, 48'h0, 16'(n + 16'ha000));
      send_request(scht_pkg::MODE_SPARE, 48'h0, 16'h0);
      send_request(scht_pkg::MODE_REMOVE, 48'h0, 16'h0);
      send_request(scht_pkg::MODE_REMOVE, k, 16'h0);
      send_request(scht_pkg::MODE_LOOKUP, k, 16'h0);
      send_request(scht_pkg::MODE_LOOKUP, {16'h8000, 16'h8000, 16'h8000}, 16'h0);
      send_request(scht_pkg::MODE_LOOKUP, {16'hffff, 16'hffff, 16'hffff}, 16'h0);
      wait_drained();
      // hold off once until every reply is back
      repeat (10) @(posedge clock);

      // random: mostly reuse recent keys so removes and lookups hit
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            sender_idle_pct = 77;
            receiver_idle_pct = 32;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         if (recent_keys.size() > 0 && $urandom_range(99) < 60)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
         else
            k = random_key();
         pick = $urandom_range(9);
         if (pick < 4)
            mode = scht_pkg::MODE_INSERT;
         else if (pick == 4)
            mode = scht_pkg::MODE_SPARE;
         else if (pick < 7)
            mode = scht_pkg::MODE_REMOVE;
         else
            mode = scht_pkg::MODE_LOOKUP;
         send_request(mode, k, 16'($urandom));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d replies: %0d hits, %0d full-chain inserts",
               table_sb.checked, table_sb.hits, table_sb.fulls);
      if (table_sb.errors == 0 && table_sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+sv
sv/scht_pkg.sv
sv/scht_ram.sv
sv/scht_ctrl.sv
sv/scht_dp.sv
sv/spatial_cell_hash_table.sv
tb/testbench.sv
